// ===== sv/ctt_pkg.sv =====
package ctt_pkg;

  // window of pending entries and follower count
  localparam int WINDOW        = 64;
  localparam int NUM_FOLLOWERS = 2;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = SLOT_W + 1;

  localparam logic [31:0] TERM_RESET = 32'd1;
  localparam logic [1:0]  ACKS_RESET = 2'd1;

  // result status codes
  localparam logic [2:0] STAT_COMMIT   = 3'd0;
  localparam logic [2:0] STAT_ACCEPTED = 3'd1;
  localparam logic [2:0] STAT_STALE    = 3'd2;
  localparam logic [2:0] STAT_DUP      = 3'd3;
  localparam logic [2:0] STAT_WINDOW   = 3'd4;

  // request kinds
  localparam logic REQ_LEADER   = 1'b0;
  localparam logic REQ_FOLLOWER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAD,
    ST_ACK,
    ST_CREAD,
    ST_CCHECK
  } ctt_state_t;

  typedef logic [NUM_FOLLOWERS-1:0] ctt_acks_t;

endpackage

// ===== sv/ctt_ram.sv =====
module ctt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/consensus_commit_tracker.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// request   | start / busy       | req_type msg_term entry_index entry_term
//           |                    | follower_id success match_index
// result    | done (one cycle)   | status commit_index commit_term last
// config    | cfg_we             | cfg_data (acks_needed)
//
// a leader entry is accepted, then evaluated in ST_LEAD; its result shows in the
// next cycle, when a new request may already be taken
// a successful follower response runs an ack walk and then its commit steps, and stops
// at WINDOW commits or at the top index: the ack walk reads every
// slot of the index/term ram once, and each commit step is a ram read followed by a
// check, both through the single port of that ram
// a failed response is accepted and finished in its accept cycle
// rst is synchronous, active high; valid bits and ack bits clear at once, the slot ram
// holds nothing that is read before it is written
// the receiver cannot stall: each result is shown on done for exactly one cycle
module consensus_commit_tracker
  import ctt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request transaction
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [31:0] msg_term,
  input  logic [31:0] entry_index,
  input  logic [31:0] entry_term,
  input  logic        follower_id,
  input  logic        success,
  input  logic [31:0] match_index,
  // result transaction
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] commit_index,
  output logic [31:0] commit_term,
  output logic        last,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);

  ctt_state_t state, state_next;

  // architectural state
  logic [1:0]  acks_needed;
  logic [31:0] current_term;
  logic [31:0] commit_point;
  logic        slot_valid [WINDOW];
  ctt_acks_t   slot_acks  [WINDOW];

  // latched request
  logic        lat_type;
  logic [31:0] lat_mterm;
  logic [31:0] lat_idx;
  logic [31:0] lat_eterm;
  logic        lat_fid;
  logic [31:0] lat_match;

  // walk / commit counter, counts up to WINDOW itself
  logic [CNT_W-1:0] cnt;

  // commit result held back until we know whether it is the last one
  logic        hold_valid;
  logic [31:0] hold_index;
  logic [31:0] hold_term;

  // slot ram: {index, term}
  logic              ram_we;
  logic [SLOT_W-1:0] ram_addr;
  logic [63:0]       ram_wdata;
  logic [63:0]       ram_rdata;
  logic [31:0]       rd_index;
  logic [31:0]       rd_term;

  logic accept;
  logic fid_ok;

  // control from the output decode
  logic        done_next;
  logic [2:0]  status_next;
  logic [31:0] res_index_next;
  logic [31:0] res_term_next;
  logic        last_next;
  logic        term_adopt;
  logic        lead_clear;
  logic        lead_store;
  logic        ack_en;
  logic        commit_en;
  logic        hold_load;
  logic        hold_drop;

  // shared datapath terms
  logic [31:0]       cp_inc;
  logic [SLOT_W-1:0] lead_slot;
  logic [SLOT_W-1:0] ack_slot;
  logic [SLOT_W-1:0] commit_slot;
  logic [31:0]       idx_gap;
  logic              lead_slot_busy;
  logic [31:0]       ack_cnt;
  logic              commit_ok;
  logic              commit_stop;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign fid_ok = (32'(follower_id) < 32'(NUM_FOLLOWERS));

  assign rd_index = ram_rdata[63:32];
  assign rd_term  = ram_rdata[31:0];

  assign cp_inc      = commit_point + 32'd1;
  assign lead_slot   = lat_idx[SLOT_W-1:0];
  assign ack_slot    = SLOT_W'(cnt - CNT_W'(1));
  assign commit_slot = cp_inc[SLOT_W-1:0];
  assign idx_gap     = lat_idx - commit_point;
  // a newer term empties the window before the entry is checked
  assign lead_slot_busy = (lat_mterm > current_term) ? 1'b0 : slot_valid[lead_slot];
  assign ack_cnt     = 32'($countones(slot_acks[commit_slot]));
  assign commit_ok   = slot_valid[commit_slot] && (rd_index == cp_inc) &&
                       (ack_cnt >= {30'd0, acks_needed});
  assign commit_stop = (commit_point == 32'hFFFF_FFFF) || (cnt == CNT_W'(WINDOW));

  ctt_ram #(
    .WIDTH (64),
    .DEPTH (WINDOW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_LEADER) begin
            state_next = ST_LEAD;
          end else if (success && fid_ok) begin
            state_next = ST_ACK;
          end
        end
      end
      ST_LEAD: begin
        state_next = ST_IDLE;
      end
      ST_ACK: begin
        if (cnt == CNT_W'(WINDOW)) begin
          state_next = ST_CREAD;
        end
      end
      ST_CREAD: begin
        state_next = commit_stop ? ST_IDLE : ST_CCHECK;
      end
      ST_CCHECK: begin
        state_next = commit_ok ? ST_CREAD : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output and datapath control
  always_comb begin
    ram_we         = 1'b0;
    ram_addr       = cnt[SLOT_W-1:0];
    ram_wdata      = {lat_idx, lat_eterm};
    done_next      = 1'b0;
    status_next    = STAT_COMMIT;
    res_index_next = hold_index;
    res_term_next  = hold_term;
    last_next      = 1'b0;
    term_adopt     = 1'b0;
    lead_clear     = 1'b0;
    lead_store     = 1'b0;
    ack_en         = 1'b0;
    commit_en      = 1'b0;
    hold_load      = 1'b0;
    hold_drop      = 1'b0;
    case (state)
      ST_LEAD: begin
        done_next      = 1'b1;
        last_next      = 1'b1;
        res_index_next = lat_idx;
        res_term_next  = lat_eterm;
        ram_addr       = lead_slot;
        if (lat_mterm < current_term) begin
          status_next = STAT_STALE;
        end else begin
          if (lat_mterm > current_term) begin
            term_adopt = 1'b1;
            lead_clear = 1'b1;
          end
          if (lat_idx <= commit_point) begin
            status_next = STAT_DUP;
          end else if (idx_gap > 32'(WINDOW)) begin
            status_next = STAT_WINDOW;
          end else if (lead_slot_busy) begin
            status_next = STAT_DUP;
          end else begin
            status_next = STAT_ACCEPTED;
            lead_store  = 1'b1;
            ram_we      = 1'b1;
          end
        end
      end
      ST_ACK: begin
        // read issued for slot cnt, data for slot cnt-1 arrives now
        ram_addr = cnt[SLOT_W-1:0];
        ack_en   = (cnt != '0) && slot_valid[ack_slot] && (rd_index <= lat_match);
      end
      ST_CREAD: begin
        ram_addr = commit_slot;
        if (commit_stop) begin
          done_next = hold_valid;
          last_next = 1'b1;
          hold_drop = 1'b1;
        end
      end
      ST_CCHECK: begin
        ram_addr  = commit_slot;
        done_next = hold_valid;
        if (commit_ok) begin
          commit_en = 1'b1;
          hold_load = 1'b1;
        end else begin
          last_next = 1'b1;
          hold_drop = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      acks_needed  <= ACKS_RESET;
      current_term <= TERM_RESET;
      commit_point <= '0;
      cnt          <= '0;
      hold_valid   <= 1'b0;
      done         <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_valid[i] <= 1'b0;
        slot_acks[i]  <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;

      if (cfg_we) begin
        acks_needed <= cfg_data;
      end

      if (accept) begin
        cnt <= '0;
      end else if (state == ST_ACK) begin
        cnt <= (cnt == CNT_W'(WINDOW)) ? '0 : cnt + CNT_W'(1);
      end else if (commit_en) begin
        cnt <= cnt + CNT_W'(1);
      end

      if (term_adopt) begin
        current_term <= lat_mterm;
      end
      if (lead_clear) begin
        // only the entry stored with the newer term survives the clear
        for (int i = 0; i < WINDOW; i++) begin
          slot_valid[i] <= lead_store && (SLOT_W'(i) == lead_slot);
          slot_acks[i]  <= '0;
        end
      end else if (lead_store) begin
        slot_valid[lead_slot] <= 1'b1;
        slot_acks[lead_slot]  <= '0;
      end

      if (ack_en) begin
        slot_acks[ack_slot][lat_fid] <= 1'b1;
      end

      if (commit_en) begin
        commit_point             <= cp_inc;
        slot_valid[commit_slot]  <= 1'b0;
        slot_acks[commit_slot]   <= '0;
      end

      if (hold_load) begin
        hold_valid <= 1'b1;
      end else if (hold_drop) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      lat_type  <= req_type;
      lat_mterm <= msg_term;
      lat_idx   <= entry_index;
      lat_eterm <= entry_term;
      lat_fid   <= follower_id;
      lat_match <= match_index;
    end
    if (hold_load) begin
      hold_index <= cp_inc;
      hold_term  <= rd_term;
    end
    status       <= status_next;
    commit_index <= res_index_next;
    commit_term  <= res_term_next;
    last         <= last_next;
  end

  // a leader result only comes out of a latched leader request
  a_lead_type: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEAD) |-> (lat_type == REQ_LEADER))
    else $error("leader evaluation without leader request");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) != ST_IDLE))
    else $error("result without work in progress");

  a_cp_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (commit_point >= $past(commit_point)))
    else $error("commit point moved backwards");

  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_COMMIT)) |-> (commit_index <= commit_point))
    else $error("commit result beyond commit point");

  a_lead_last: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_COMMIT)) |-> last)
    else $error("leader result not marked last");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ctt_pkg::*;

  // generous ceiling: a full commit sweep walks the whole window and then commits per response
  localparam int CYCLE_LIMIT   = 400000;
  // quiet time after the last result: an ack walk with no commit still walks the whole window
  localparam int SETTLE_CYCLES = 2 * WINDOW + 20;

  typedef struct {
    logic        req_type;
    logic [31:0] msg_term;
    logic [31:0] entry_index;
    logic [31:0] entry_term;
    logic        follower_id;
    logic        success;
    logic [31:0] match_index;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] index;
    logic [31:0] term;
    logic        last;
  } outcome_t;

  typedef struct {
    request_t req;
    bit       typed;
    outcome_t want;
  } step_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all driven from time zero
  logic        start       = 1'b0;
  logic        req_type    = 1'b0;
  logic [31:0] msg_term    = '0;
  logic [31:0] entry_index = '0;
  logic [31:0] entry_term  = '0;
  logic        follower_id = 1'b0;
  logic        success     = 1'b0;
  logic [31:0] match_index = '0;
  logic        cfg_we      = 1'b0;
  logic [1:0]  cfg_data    = '0;

  // block outputs
  logic        busy;
  logic        done;
  logic [2:0]  status;
  logic [31:0] commit_index;
  logic [31:0] commit_term;
  logic        last;

  consensus_commit_tracker dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .msg_term     (msg_term),
    .entry_index  (entry_index),
    .entry_term   (entry_term),
    .follower_id  (follower_id),
    .success      (success),
    .match_index  (match_index),
    .done         (done),
    .status       (status),
    .commit_index (commit_index),
    .commit_term  (commit_term),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // tracker state as the testbench sees it
  logic [1:0]  acks_req    = ACKS_RESET;
  logic [31:0] term_now    = TERM_RESET;
  logic [31:0] commit_point = '0;
  logic        slot_live [WINDOW];
  logic [31:0] slot_idx  [WINDOW];
  logic [31:0] slot_trm  [WINDOW];
  ctt_acks_t   slot_ack  [WINDOW];

  outcome_t awaited_results [$];   // results still owed by the block, oldest first
  outcome_t step_results [$];      // results of the transaction just accepted
  step_t    directed_rows [$];
  outcome_t no_outcome;

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  sent_count  = 0;
  bit  gaps_on     = 1'b1;

  initial begin
    no_outcome = '{default: '0};
    for (int i = 0; i < WINDOW; i++) begin
      slot_live[i] = 1'b0;
      slot_idx[i]  = '0;
      slot_trm[i]  = '0;
      slot_ack[i]  = '0;
    end
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // predictor: updates the tracker state and fills step_results for one transaction
  function automatic void track_request(input request_t r);
    logic [31:0]       next;
    logic [SLOT_W-1:0] s;
    logic [2:0]        st;
    outcome_t          o;
    int                n;
    step_results.delete();
    if (r.req_type == REQ_LEADER) begin
      if (r.msg_term < term_now) begin
        st = STAT_STALE;
      end else begin
        // a newer term empties the window before the entry is looked at
        if (r.msg_term > term_now) begin
          term_now = r.msg_term;
          for (int i = 0; i < WINDOW; i++) begin
            slot_live[i] = 1'b0;
            slot_ack[i]  = '0;
          end
        end
        s = r.entry_index[SLOT_W-1:0];
        if (r.entry_index <= commit_point) begin
          st = STAT_DUP;
        end else if (r.entry_index - commit_point > 32'(WINDOW)) begin
          st = STAT_WINDOW;
        end else if (slot_live[s]) begin
          st = STAT_DUP;
        end else begin
          slot_live[s] = 1'b1;
          slot_idx[s]  = r.entry_index;
          slot_trm[s]  = r.entry_term;
          slot_ack[s]  = '0;
          st = STAT_ACCEPTED;
        end
      end
      o = '{status: st, index: r.entry_index, term: r.entry_term, last: 1'b1};
      step_results.insert(step_results.size(), o);
    end else if (r.success && int'(r.follower_id) < NUM_FOLLOWERS) begin
      // mark this follower on every pending entry it already holds
      for (int i = 0; i < WINDOW; i++) begin
        if (slot_live[i] && slot_idx[i] <= r.match_index)
          slot_ack[i][r.follower_id] = 1'b1;
      end
      // commit in order while the next entry has enough acks
      n = 0;
      while (n < WINDOW && commit_point != 32'hFFFF_FFFF) begin
        next = commit_point + 32'd1;
        s = next[SLOT_W-1:0];
        if (!slot_live[s] || slot_idx[s] != next || $countones(slot_ack[s]) < int'(acks_req))
          break;
        o = '{status: STAT_COMMIT, index: next, term: slot_trm[s], last: 1'b0};
        step_results.insert(step_results.size(), o);
        slot_live[s] = 1'b0;
        slot_ack[s]  = '0;
        commit_point = next;
        n++;
      end
      if (n > 0) step_results[n-1].last = 1'b1;
    end
  endfunction

  function automatic request_t leader_req(input logic [31:0] mt, idx, et);
    request_t r;
    r = '{default: '0};
    r.req_type    = REQ_LEADER;
    r.msg_term    = mt;
    r.entry_index = idx;
    r.entry_term  = et;
    return r;
  endfunction

  function automatic request_t follower_req(input logic fid, ok, input logic [31:0] mi);
    request_t r;
    r = '{default: '0};
    r.req_type    = REQ_FOLLOWER;
    r.follower_id = fid;
    r.success     = ok;
    r.match_index = mi;
    return r;
  endfunction

  // one request transaction; start stays high on return so back-to-back items need no
  // second assignment in the same step
  task automatic send_request(input request_t r, input bit typed, input outcome_t want);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= r.req_type;
    msg_term    <= r.msg_term;
    entry_index <= r.entry_index;
    entry_term  <= r.entry_term;
    follower_id <= r.follower_id;
    success     <= r.success;
    match_index <= r.match_index;
    do @(posedge clk); while (busy);
    // accepted at this edge
    track_request(r);
    if (typed) awaited_results.insert(awaited_results.size(), want);
    else foreach (step_results[i])
      awaited_results.insert(awaited_results.size(), step_results[i]);
    sent_count++;
  endtask

  // sender holds off until every owed result is in and the block has gone quiet
  task automatic settle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_acks(input logic [1:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    acks_req = v;
  endtask

  task automatic add_row(input request_t r, input bit typed, input logic [2:0] st);
    step_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = '{status: st, index: r.entry_index, term: r.entry_term, last: 1'b1};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // well-formed run: consecutive entries above the commit point, then follower acks
  task automatic run_burst();
    int          k;
    int          reps;
    bit          backward;
    logic [31:0] base;
    logic [31:0] mt;
    logic [31:0] idx;
    logic [31:0] mi;
    k = ($urandom_range(0, 11) == 0) ? WINDOW : $urandom_range(1, 8);
    base = commit_point;
    mt = term_now;
    if (term_now != 32'hFFFF_FFFF && $urandom_range(0, 9) == 0) mt = term_now + 32'd1;
    backward = ($urandom_range(0, 3) == 0);
    for (int j = 0; j < k; j++) begin
      idx = backward ? base + 32'(k - j) : base + 32'(j + 1);
      // an occasional hole or repeat inside the run
      if ($urandom_range(0, 11) != 0) send_request(leader_req(mt, idx, $urandom()), 0, no_outcome);
      if ($urandom_range(0, 11) == 0) send_request(leader_req(mt, idx, $urandom()), 0, no_outcome);
    end
    reps = (acks_req >= 2) ? $urandom_range(2, 4) : $urandom_range(1, 3);
    repeat (reps) begin
      mi = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : base + 32'($urandom_range(0, k + 1));
      send_request(follower_req(1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0, mi), 0,
                   no_outcome);
    end
  endtask

  // loose transactions: stale or wild terms, indexes anywhere, random responses
  task automatic send_noise(input bit wild);
    logic [31:0] mt;
    logic [31:0] idx;
    logic [31:0] mi;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 2))
        0:       mt = $urandom_range(0, term_now);
        1:       mt = term_now;
        default: mt = wild ? $urandom() : term_now;
      endcase
      case ($urandom_range(0, 3))
        0:       idx = $urandom();
        1:       idx = commit_point - 32'($urandom_range(0, 3));
        2:       idx = commit_point + 32'(WINDOW + $urandom_range(1, 3));
        default: idx = commit_point + 32'($urandom_range(1, WINDOW));
      endcase
      send_request(leader_req(mt, idx, $urandom()), 0, no_outcome);
    end else begin
      mi = ($urandom_range(0, 1) == 0) ? $urandom() : commit_point + 32'($urandom_range(0, 8));
      send_request(follower_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), mi), 0,
                   no_outcome);
    end
  endtask

  task automatic run_phase(input int items, input bit wild, input bit allow_gaps);
    int target;
    target = sent_count + items;
    while (sent_count < target) begin
      // idle stretches come and go; none at all when allow_gaps is off
      gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 65) run_burst();
      else send_noise(wild);
      if (allow_gaps && $urandom_range(0, 24) == 0) settle();
    end
  endtask

  // result checker: every done cycle is one result transaction
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result status %0d index %0d", status, commit_index));
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status)
          report($sformatf("index %0d: status %0d, expected %0d",
                           want.index, status, want.status));
        if (commit_index !== want.index)
          report($sformatf("commit_index %0d, expected %0d", commit_index, want.index));
        if (commit_term !== want.term)
          report($sformatf("index %0d: commit_term %0h, expected %0h",
                           want.index, commit_term, want.term));
        if (last !== want.last)
          report($sformatf("index %0d: last %0b, expected %0b", want.index, last, want.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, acks_needed at its reset value of one
    add_row(leader_req(32'd0, 32'd1, 32'd5), 1, STAT_STALE);           // term below current
    add_row(leader_req(32'd1, 32'd0, 32'd7), 1, STAT_DUP);             // at commit point
    add_row(leader_req(32'd1, 32'd65, 32'd8), 1, STAT_WINDOW);         // one past window
    add_row(leader_req(32'd1, 32'd64, 32'd9), 1, STAT_ACCEPTED);       // top of window
    add_row(leader_req(32'd1, 32'd1, 32'hFFFF_FFFF), 1, STAT_ACCEPTED);
    add_row(leader_req(32'd1, 32'd1, 32'd4), 1, STAT_DUP);             // slot already held
    add_row(leader_req(32'd1, 32'hFFFF_FFFF, 32'd0), 1, STAT_WINDOW);  // largest index
    add_row(follower_req(1'b0, 1'b0, 32'hFFFF_FFFF), 0, STAT_COMMIT);  // failed response
    add_row(follower_req(1'b0, 1'b1, 32'd0), 0, STAT_COMMIT);          // acks nothing
    add_row(leader_req(32'd1, 32'd2, 32'd3), 1, STAT_ACCEPTED);
    add_row(follower_req(1'b1, 1'b1, 32'd1), 0, STAT_COMMIT);          // commits entry 1
    add_row(follower_req(1'b1, 1'b1, 32'd1), 0, STAT_COMMIT);          // repeated ack
    add_row(follower_req(1'b0, 1'b1, 32'd2), 0, STAT_COMMIT);          // commits entry 2
    add_row(leader_req(32'd3, 32'd3, 32'd3), 0, STAT_COMMIT);          // newer term clears
    add_row(leader_req(32'd2, 32'd4, 32'd3), 1, STAT_STALE);
    add_row(leader_req(32'd3, 32'd66, 32'd6), 0, STAT_COMMIT);         // window edge
    add_row(leader_req(32'd3, 32'd67, 32'd6), 0, STAT_COMMIT);         // just outside
    add_row(follower_req(1'b0, 1'b1, 32'hFFFF_FFFF), 0, STAT_COMMIT);  // stops at the hole
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // random part across settings, extremes of the register included
    run_phase(70, 1'b0, 1'b1);
    write_acks(2'd2);
    run_phase(60, 1'b0, 1'b1);
    write_acks(2'd3);   // more acks than followers: nothing commits
    run_phase(20, 1'b0, 1'b1);
    write_acks(2'd0);   // any successful response commits the pending run
    run_phase(30, 1'b0, 1'b1);
    write_acks(2'd1);

    // last stretch at the largest term, no idling; random terms are now mostly stale
    gaps_on = 1'b0;
    send_request(leader_req(32'hFFFF_FFFF, commit_point + 32'd1, $urandom()), 0, no_outcome);
    run_phase(40, 1'b1, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ctt_pkg.sv
sv/ctt_ram.sv
sv/consensus_commit_tracker.sv
tb/testbench.sv
